// ===== hdl/dpfrc_pkg.sv =====
// Package for the duplicate-dropping packet FIFO with range count.
// Holds request codes, payload structs, the token that travels the cell chain
// and the size constants. No dependencies.
`timescale 1ns / 1ps

package dpfrc_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int LIMIT_W       = 7;
    localparam int CNT_W         = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic [CNT_W-1:0]   COUNT_MAX   = 7'd127;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_FWD   = 2'd1;
    localparam logic [1:0] REQ_COUNT = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] pkt_source;
        logic [15:0] pkt_destination;
        logic [31:0] pkt_timestamp;
        logic [31:0] range_start;
        logic [31:0] range_end;
    } req_t;

    typedef struct packed {
        logic             add_accepted;
        logic             fwd_valid;
        logic [15:0]      fwd_source;
        logic [15:0]      fwd_destination;
        logic [31:0]      fwd_timestamp;
        logic [CNT_W-1:0] match_count;
    } rsp_t;

    typedef struct packed {
        logic [15:0] src;
        logic [15:0] dst;
        logic [31:0] ts;
    } entry_t;

    // Partial results carried from cell to cell during a scan.
    typedef struct packed {
        logic             valid;
        logic             dup;
        logic [CNT_W-1:0] cnt;
    } token_t;

    // Store update broadcast to every cell.
    typedef struct packed {
        logic   shift;
        entry_t wr_entry;
    } upd_t;

endpackage

// ===== hdl/dpfrc_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Used for the request and response channels; depends on nothing.
`timescale 1ns / 1ps

interface dpfrc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/dpfrc_cell.sv =====
// One storage cell of the FIFO chain: holds one entry and its valid bit,
// compares it against the current request and forwards the scan token.
// Depends on dpfrc_pkg.
`timescale 1ns / 1ps

module dpfrc_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  dpfrc_pkg::req_t   query,
    input  dpfrc_pkg::token_t tok_in,
    output dpfrc_pkg::token_t tok_out,
    input  dpfrc_pkg::upd_t   upd,
    input  logic            wr_en,
    input  logic            nb_valid,
    input  dpfrc_pkg::entry_t nb_entry,
    output logic            valid,
    output dpfrc_pkg::entry_t entry
);
    import dpfrc_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    token_t tok_reg, tok_next;
    logic   dup_hit;
    logic   cnt_hit;

    assign dup_hit = valid_reg && entry_reg.src == query.pkt_source
                     && entry_reg.dst == query.pkt_destination
                     && entry_reg.ts == query.pkt_timestamp;
    assign cnt_hit = valid_reg && entry_reg.dst == query.pkt_destination
                     && entry_reg.ts >= query.range_start
                     && entry_reg.ts <= query.range_end;

    always_comb
    begin
        tok_next       = tok_in;
        tok_next.dup   = tok_in.dup | dup_hit;
        if (cnt_hit && tok_in.cnt != COUNT_MAX)
        begin
            tok_next.cnt = tok_in.cnt + 1'b1;
        end
    end

    // A write lands after the shift, so it wins when both hit this cell.
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (wr_en)
        begin
            valid_next = 1'b1;
            entry_next = upd.wr_entry;
        end
        else if (upd.shift)
        begin
            valid_next = nb_valid;
            entry_next = nb_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign tok_out = tok_reg;
    assign valid   = valid_reg;
    assign entry   = entry_reg;

endmodule

// ===== hdl/dedup_packet_fifo_with_range_count_core.sv =====
// Top level of the duplicate-dropping packet FIFO with range count.
// Instantiates the chain of dpfrc_cell; depends on dpfrc_pkg and dpfrc_stream_if.
//
// Usage:
//   req carries one request per transfer: add, forward, count or no-op.
//   rsp returns exactly one result per request, in request order.
//   cfg_we/cfg_wdata write memory_limit (0 acts as 1, above DEPTH acts as DEPTH);
//   write it only while no request is in flight.
// Entries live in a row of DEPTH cells, oldest in cell 0. A forward or an
// eviction shifts every cell down by one, all cells together.
// Add and count send a token down the chain, one cell per cycle, which
// gathers the duplicate flag and the match count. For an add or count the
// request is registered, the token passes every cell, the result at the
// chain end is captured and the finish state commits it; forward and no-op go
// straight to the finish state. The next request is taken after the commit.
// The result sits in an output register; the block takes the next request
// while it waits. If rsp stalls, a finished request holds its commit until
// the output register frees, and no request is taken meanwhile.
// Reset empties the FIFO (all valid bits cleared at once) and sets
// memory_limit to 64.
`timescale 1ns / 1ps

module dedup_packet_fifo_with_range_count_core #(
    parameter int DEPTH = dpfrc_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    dpfrc_stream_if.sink                    req,
    dpfrc_stream_if.source                  rsp,
    input  logic                            cfg_we,
    input  logic [dpfrc_pkg::LIMIT_W-1:0]   cfg_wdata
);
    import dpfrc_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic               launch_reg, launch_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    req_t               q_reg;
    logic               dup_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;

    token_t             tok [DEPTH+1];
    logic [DEPTH-1:0]   tok_vld;
    logic [DEPTH-1:0]   cell_valid;
    entry_t             cell_entry [DEPTH];
    upd_t               upd;
    logic               upd_shift;
    logic               wr_do;
    logic [IDX_W-1:0]   wr_idx;

    logic               req_fire;
    logic               out_free;
    logic               pop;
    logic [CMP_W-1:0]   lim_ext;
    logic [OCC_W-1:0]   lim;
    logic [OCC_W-1:0]   wr_pos;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign lim_ext = (limit_reg == '0) ? CMP_W'(1) :
                     (CMP_W'(limit_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) :
                     CMP_W'(limit_reg);
    assign lim     = lim_ext[OCC_W-1:0];
    assign pop     = (occ_reg >= lim);
    assign wr_pos  = pop ? occ_reg - 1'b1 : occ_reg;
    assign wr_idx  = wr_pos[IDX_W-1:0];

    assign tok[0].valid = launch_reg;
    assign tok[0].dup   = 1'b0;
    assign tok[0].cnt   = '0;

    assign upd = '{shift: upd_shift,
                   wr_entry: '{src: q_reg.pkt_source,
                               dst: q_reg.pkt_destination,
                               ts: q_reg.pkt_timestamp}};

    always_comb
    begin
        state_next     = state_reg;
        launch_next    = 1'b0;
        occ_next       = occ_reg;
        upd_shift      = 1'b0;
        wr_do          = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.data.req_type == REQ_ADD || req.data.req_type == REQ_COUNT)
                    begin
                        state_next  = ST_SCAN;
                        launch_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (tok[DEPTH].valid)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    case (q_reg.req_type)
                        REQ_ADD:
                        begin
                            if (!dup_reg)
                            begin
                                out_next.add_accepted = 1'b1;
                                upd_shift             = pop;
                                wr_do                 = 1'b1;
                                occ_next              = pop ? occ_reg : occ_reg + 1'b1;
                            end
                        end
                        REQ_FWD:
                        begin
                            if (occ_reg != '0)
                            begin
                                out_next.fwd_valid       = 1'b1;
                                out_next.fwd_source      = cell_entry[0].src;
                                out_next.fwd_destination = cell_entry[0].dst;
                                out_next.fwd_timestamp   = cell_entry[0].ts;
                                upd_shift                = 1'b1;
                                occ_next                 = occ_reg - 1'b1;
                            end
                        end
                        REQ_COUNT:
                        begin
                            out_next.match_count = cnt_reg;
                        end
                        default:
                        begin
                            out_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (req_fire)
        begin
            q_reg <= req.data;
        end
        if (state_reg == ST_SCAN && tok[DEPTH].valid)
        begin
            dup_reg <= tok[DEPTH].dup;
            cnt_reg <= tok[DEPTH].cnt;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic   nb_valid;
        entry_t nb_entry;

        if (i < DEPTH - 1)
        begin : g_mid
            assign nb_valid = cell_valid[i+1];
            assign nb_entry = cell_entry[i+1];
        end
        else
        begin : g_last
            assign nb_valid = 1'b0;
            assign nb_entry = '0;
        end

        dpfrc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .query    (q_reg),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1]),
            .upd      (upd),
            .wr_en    (wr_do && wr_idx == IDX_W'(i)),
            .nb_valid (nb_valid),
            .nb_entry (nb_entry),
            .valid    (cell_valid[i]),
            .entry    (cell_entry[i])
        );

        assign tok_vld[i] = tok[i+1].valid;
    end

    // Only one scan token may ever be in the chain.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({launch_reg, tok_vld}))
        else $error("more than one scan token in the cell chain");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy exceeds depth");

    // The cells stay packed from cell 0, so cell 0 holds an entry exactly when non-empty.
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[0] == (occ_reg != '0))
        else $error("head cell valid bit disagrees with occupancy");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg != ST_IDLE)
        else $error("controller idle right after taking a request");

    a_scan_launch: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> state_reg == ST_SCAN)
        else $error("scan token launched outside a scan");

endmodule

// ===== bench/dpfrc_checker.sv =====
// Response checker for the duplicate-dropping packet FIFO: it watches the request,
// response and register write ports, keeps its own copy of the stored packets and
// compares every response. Depends on dpfrc_pkg.
`timescale 1ns / 1ps

module dpfrc_checker #(
    parameter int DEPTH = dpfrc_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  dpfrc_pkg::req_t               req_data,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  dpfrc_pkg::rsp_t               rsp_data,
    input  logic                          cfg_we,
    input  logic [dpfrc_pkg::LIMIT_W-1:0] cfg_wdata,
    output int unsigned                   fail_count,
    output int unsigned                   outstanding
);
    import dpfrc_pkg::*;

    // Stored packets, oldest at index 0.
    entry_t             shadow_fifo[$];
    rsp_t               expected_rsp_q[$];
    logic [LIMIT_W-1:0] limit_reg;
    int unsigned        mismatches;

    function automatic int unsigned active_limit();
        int unsigned lim;
        lim = limit_reg;
        if (lim == 0)
        begin
            lim = 1;
        end
        if (lim > DEPTH)
        begin
            lim = DEPTH;
        end
        return lim;
    endfunction

    // Applies one request to the shadow store and returns the response it must give.
    function automatic rsp_t predict_response(input req_t r);
        rsp_t        res;
        entry_t      pkt;
        bit          dup;
        int unsigned hits;
        res     = '0;
        pkt.src = r.pkt_source;
        pkt.dst = r.pkt_destination;
        pkt.ts  = r.pkt_timestamp;
        dup     = 1'b0;
        hits    = 0;
        case (r.req_type)
            REQ_ADD:
            begin
                foreach (shadow_fifo[i])
                begin
                    if (shadow_fifo[i] == pkt)
                    begin
                        dup = 1'b1;
                    end
                end
                if (!dup)
                begin
                    // A full store drops only its oldest entry, even when the limit
                    // was lowered below the current fill level.
                    if (shadow_fifo.size() >= active_limit())
                    begin
                        shadow_fifo.delete(0);
                    end
                    shadow_fifo.insert(shadow_fifo.size(), pkt);
                    res.add_accepted = 1'b1;
                end
            end
            REQ_FWD:
            begin
                if (shadow_fifo.size() != 0)
                begin
                    res.fwd_valid       = 1'b1;
                    res.fwd_source      = shadow_fifo[0].src;
                    res.fwd_destination = shadow_fifo[0].dst;
                    res.fwd_timestamp   = shadow_fifo[0].ts;
                    shadow_fifo.delete(0);
                end
            end
            REQ_COUNT:
            begin
                foreach (shadow_fifo[i])
                begin
                    if (shadow_fifo[i].dst == r.pkt_destination &&
                        shadow_fifo[i].ts >= r.range_start &&
                        shadow_fifo[i].ts <= r.range_end)
                    begin
                        hits++;
                    end
                end
                if (hits > COUNT_MAX)
                begin
                    hits = COUNT_MAX;
                end
                res.match_count = CNT_W'(hits);
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic string rsp_text(input rsp_t r);
        return $sformatf("acc=%b fwd=%b src=%h dst=%h ts=%h cnt=%0d", r.add_accepted,
                         r.fwd_valid, r.fwd_source, r.fwd_destination, r.fwd_timestamp,
                         r.match_count);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_rsp;
        if (!rst_n)
        begin
            shadow_fifo.delete();
            expected_rsp_q.delete();
            limit_reg   = LIMIT_RESET;
            mismatches  = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg = cfg_wdata;
            end
            if (req_valid && req_ready)
            begin
                expected_rsp_q.insert(expected_rsp_q.size(), predict_response(req_data));
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("[%0t] response with no request waiting: %s", $time,
                                 rsp_text(rsp_data));
                    end
                end
                else
                begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (rsp_data.add_accepted !== exp_rsp.add_accepted ||
                        rsp_data.fwd_valid !== exp_rsp.fwd_valid ||
                        rsp_data.fwd_source !== exp_rsp.fwd_source ||
                        rsp_data.fwd_destination !== exp_rsp.fwd_destination ||
                        rsp_data.fwd_timestamp !== exp_rsp.fwd_timestamp ||
                        rsp_data.match_count !== exp_rsp.match_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("[%0t] response mismatch: expected %s, got %s", $time,
                                     rsp_text(exp_rsp), rsp_text(rsp_data));
                        end
                    end
                end
            end
            outstanding <= expected_rsp_q.size();
            fail_count  <= mismatches;
        end
    end

endmodule

// ===== bench/tb_dedup_packet_fifo_with_range_count_core.sv =====
// Top of the packet FIFO regression: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on dpfrc_pkg, dpfrc_stream_if, dpfrc_checker
// and the dedup_packet_fifo_with_range_count_core RTL.
`timescale 1ns / 1ps

module tb_dedup_packet_fifo_with_range_count_core;
    import dpfrc_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int LATENCY     = DEPTH + 3;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 800000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;
    int unsigned        fail_count;
    int unsigned        outstanding;
    int unsigned        cycle_count = 0;
    int unsigned        idle_pct = 0;
    int unsigned        stall_pct = 0;
    bit                 hold_req = 1'b0;
    // Recently added packets, reused to provoke duplicate rejections.
    entry_t             recent_adds[$];

    dpfrc_stream_if #(.T(req_t)) req_ch ();
    dpfrc_stream_if #(.T(rsp_t)) rsp_ch ();

    dedup_packet_fifo_with_range_count_core #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    dpfrc_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_ch.valid),
        .req_ready  (req_ch.ready),
        .req_data   (req_ch.data),
        .rsp_valid  (rsp_ch.valid),
        .rsp_ready  (rsp_ch.ready),
        .rsp_data   (rsp_ch.data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("dedup_packet_fifo_with_range_count_core regression: fail");
            $finish;
        end
    end

    // Response side: random stalls, plus one long hold-off on request so that the
    // block backs up and stops taking requests.
    initial
    begin : response_drive
        int k;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                begin
                    rsp_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one request and returns at the edge where it transfers; valid stays high
    // so that a following request can go out back to back.
    task automatic send_req(input logic [1:0] kind, input logic [15:0] src,
                            input logic [15:0] dst, input logic [31:0] ts,
                            input logic [31:0] lo, input logic [31:0] hi);
        req_t item;
        item.req_type        = kind;
        item.pkt_source      = src;
        item.pkt_destination = dst;
        item.pkt_timestamp   = ts;
        item.range_start     = lo;
        item.range_end       = hi;
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count, input int unsigned sender_idle,
                              input int unsigned receiver_stall);
        int unsigned roll;
        logic [1:0]  kind;
        entry_t      pkt;
        logic [31:0] lo;
        logic [31:0] hi;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < 50)
            begin
                kind = REQ_ADD;
            end
            else if (roll < 68)
            begin
                kind = REQ_FWD;
            end
            else if (roll < 94)
            begin
                kind = REQ_COUNT;
            end
            else
            begin
                kind = REQ_NOP;
            end
            // Small value pools make duplicates and count hits frequent.
            pkt.src = ($urandom_range(99) < 70) ? 16'($urandom_range(7)) : 16'($urandom);
            pkt.dst = ($urandom_range(99) < 75) ? 16'($urandom_range(3)) : 16'($urandom);
            roll = $urandom_range(99);
            if (roll < 55)
            begin
                pkt.ts = $urandom_range(15);
            end
            else if (roll < 65)
            begin
                pkt.ts = roll[0] ? '1 : '0;
            end
            else
            begin
                pkt.ts = $urandom;
            end
            if (kind == REQ_ADD && recent_adds.size() != 0 && $urandom_range(99) < 20)
            begin
                pkt = recent_adds[$urandom_range(recent_adds.size() - 1)];
            end
            roll = $urandom_range(99);
            if (roll < 50)
            begin
                lo = $urandom_range(15);
                hi = lo + $urandom_range(15);
            end
            else if (roll < 65)
            begin
                lo = '0;
                hi = '1;
            end
            else if (roll < 75)
            begin
                // Start above end: nothing can match.
                lo = $urandom_range(31, 16);
                hi = $urandom_range(15);
            end
            else
            begin
                lo = $urandom;
                hi = $urandom;
            end
            if (kind == REQ_ADD)
            begin
                recent_adds.insert(recent_adds.size(), pkt);
                if (recent_adds.size() > 16)
                begin
                    recent_adds.delete(0);
                end
            end
            send_req(kind, pkt.src, pkt.dst, pkt.ts, lo, hi);
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (6)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes and every request type, starting from an empty store.
        send_req(REQ_FWD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
        send_req(REQ_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_req(REQ_NOP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_ADD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
        send_req(REQ_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_req(REQ_ADD, 16'h0000, 16'h0000, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_COUNT, 16'h0000, 16'hFFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_req(REQ_COUNT, 16'h0000, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
        send_req(REQ_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h1, 32'h0);
        send_req(REQ_FWD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
        send_req(REQ_FWD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
        send_req(REQ_FWD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);

        // Limit of two: a duplicate of the oldest entry in a full store is refused.
        set_limit(7'd2);
        send_req(REQ_ADD, 16'h1234, 16'h0042, 32'h100, 32'h0, 32'h0);
        send_req(REQ_ADD, 16'h1234, 16'h0042, 32'h101, 32'h0, 32'h0);
        send_req(REQ_ADD, 16'h1234, 16'h0042, 32'h100, 32'h0, 32'h0);
        send_req(REQ_COUNT, 16'h0000, 16'h0042, 32'h0, 32'h100, 32'h101);

        // A zero limit acts as one and now sits below the fill level of two.
        set_limit(7'd0);
        send_req(REQ_ADD, 16'h5678, 16'h0042, 32'h102, 32'h0, 32'h0);
        send_req(REQ_FWD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
        send_req(REQ_FWD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
        send_req(REQ_FWD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);

        set_limit(7'd64);
        run_random(300, 0, 0);
        set_limit(7'd5);
        run_random(200, 72, 0);
        set_limit(7'd127);
        hold_req = 1'b1;
        run_random(250, 0, 72);
        set_limit(7'd1);
        run_random(100, 7, 7);
        set_limit(LIMIT_W'($urandom_range(63, 2)));
        run_random(300, 7, 7);

        wait_idle();
        repeat (LATENCY + 10)
        begin
            @(posedge clk);
        end
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("dedup_packet_fifo_with_range_count_core regression: pass");
        end
        else
        begin
            $display("dedup_packet_fifo_with_range_count_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dpfrc_pkg.sv
hdl/dpfrc_stream_if.sv
hdl/dpfrc_cell.sv
hdl/dedup_packet_fifo_with_range_count_core.sv
bench/dpfrc_checker.sv
bench/tb_dedup_packet_fifo_with_range_count_core.sv
